[rtl/core/npm_pkg.sv]
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants for the naive pattern matcher.
// ----------------------------------------------------------------------------
package npm_pkg;

    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 32;
    localparam int IDX_W         = $clog2(MAX_PATTERN);
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int MATCH_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int MODE_W        = 2;
    localparam int DATA_W        = 32;
    localparam int PADDR_W       = 3;
    localparam int CFG_LEN_W     = 7;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [PADDR_W-3:0] REG_PATTERN_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_HOLD
    } npm_state_t;

    typedef struct packed {
        logic take;
        logic step;
        logic load_out;
    } npm_cmd_t;

    typedef struct packed {
        logic too_short;
        logic byte_eq;
        logic last;
        logic out_full;
    } npm_status_t;

endpackage

[rtl/core/naive_pattern_matcher_unit.sv]
// ----------------------------------------------------------------------------
// naive_pattern_matcher_unit
// Exact pattern search over a byte stream with overlapping match reporting.
// ----------------------------------------------------------------------------
// A load, restart or unused-mode item is taken with no compare. A text byte is
// taken and then compared against the pattern one byte per cycle through the
// single read port of the pattern ram; the block takes no new item until the
// compare of up to L bytes (L = effective pattern length) ends, early on a
// mismatch. No compare is made when fewer than L bytes have arrived since restart.
// A match waits in the output register until taken; a further match stalls
// the compare only while that register is still full. No clearing pass is
// needed after reset.
module naive_pattern_matcher_unit
    import npm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [IDX_W-1:0]    s_pattern_index,
    input  logic [BYTE_W-1:0]   s_byte_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MATCH_W-1:0]  m_match_start,
    output logic                m_position_saturated
);

    logic [CFG_LEN_W-1:0] pattern_length;
    npm_cmd_t             cmd;
    npm_status_t          status;

    npm_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pattern_length (pattern_length)
    );

    npm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    npm_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .s_mode               (s_mode),
        .s_pattern_index      (s_pattern_index),
        .s_byte_value         (s_byte_value),
        .pattern_length       (pattern_length),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_match_start        (m_match_start),
        .m_position_saturated (m_position_saturated)
    );

endmodule

[rtl/core/npm_regs.sv]
// ----------------------------------------------------------------------------
// npm_regs
// Configuration register file with an APB-style write/read port.
// ----------------------------------------------------------------------------
module npm_regs
    import npm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [CFG_LEN_W-1:0] pattern_length
);

    logic [CFG_LEN_W-1:0] len_reg;
    logic [CFG_LEN_W-1:0] len_next;
    logic                 sel_len;

    assign pready  = 1'b1;
    assign sel_len = (paddr[PADDR_W-1:2] == REG_PATTERN_LENGTH);

    always_comb begin
        len_next = len_reg;
        if (psel && penable && pwrite && pready && sel_len) begin
            len_next = pwdata[CFG_LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= CFG_LEN_W'(1);
        end else begin
            len_reg <= len_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_len) begin
            prdata = DATA_W'(len_reg);
        end
    end

    assign pattern_length = len_reg;

endmodule

[rtl/core/npm_datapath.sv]
// ----------------------------------------------------------------------------
// npm_datapath
// Pattern RAM, text window, scan register, counters and result register.
// ----------------------------------------------------------------------------
module npm_datapath
    import npm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  npm_cmd_t             cmd,
    output npm_status_t          status,
    input  logic [MODE_W-1:0]    s_mode,
    input  logic [IDX_W-1:0]     s_pattern_index,
    input  logic [BYTE_W-1:0]    s_byte_value,
    input  logic [CFG_LEN_W-1:0] pattern_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MATCH_W-1:0]   m_match_start,
    output logic                 m_position_saturated
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [BYTE_W-1:0]        pat_mem [MAX_PATTERN];
    logic [BYTE_W-1:0]        rdata_reg;
    logic [IDX_W-1:0]         rd_addr;

    logic [BYTE_W-1:0]        win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]        scan_reg [MAX_PATTERN];
    logic [LEN_W-1:0]         fill_reg;
    logic [LEN_W-1:0]         fill_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [IDX_W-1:0]         pidx_reg;

    logic [MATCH_W-1:0]       res_start_reg;
    logic                     res_sat_reg;
    logic                     m_valid_reg;
    logic [MATCH_W-1:0]       m_start_reg;
    logic                     m_sat_reg;

    logic [LEN_W-1:0]         eff_len;
    logic [IDX_W-1:0]         last_idx;
    logic                     take_text;
    logic                     take_load;
    logic                     take_restart;

    // effective length, clamped to 1..MAX_PATTERN
    always_comb begin
        eff_len = LEN_W'(pattern_length);
        if (pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(pattern_length) > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
    end

    assign last_idx     = IDX_W'(eff_len - LEN_W'(1));
    assign take_text    = cmd.take && (s_mode == MODE_TEXT);
    assign take_load    = cmd.take && (s_mode == MODE_LOAD);
    assign take_restart = cmd.take && (s_mode == MODE_RESTART);

    assign fill_next = (fill_reg < LEN_W'(MAX_PATTERN)) ? fill_reg + LEN_W'(1) : fill_reg;
    assign pos_next  = (pos_reg < POS_MAX) ? pos_reg + POSITION_BITS'(1) : pos_reg;

    assign rd_addr = take_text ? last_idx : pidx_reg - IDX_W'(1);

    // pattern ram
    always_ff @(posedge aclk) begin
        if (take_load) begin
            pat_mem[s_pattern_index] <= s_byte_value;
        end
        rdata_reg <= pat_mem[rd_addr];
    end

    // text window and scan copy
    always_ff @(posedge aclk) begin
        if (take_text) begin
            win_reg[0]  <= s_byte_value;
            scan_reg[0] <= s_byte_value;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                win_reg[k]  <= win_reg[k-1];
                scan_reg[k] <= win_reg[k-1];
            end
        end else if (cmd.step) begin
            for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                scan_reg[k] <= scan_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_text) begin
            pidx_reg      <= last_idx;
            res_start_reg <= MATCH_W'(pos_reg) - MATCH_W'(eff_len) + MATCH_W'(1);
            res_sat_reg   <= (pos_next == POS_MAX);
        end else if (cmd.step) begin
            pidx_reg <= pidx_reg - IDX_W'(1);
        end
        if (cmd.load_out) begin
            m_start_reg <= res_start_reg;
            m_sat_reg   <= res_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take_restart) begin
                fill_reg <= '0;
                pos_reg  <= '0;
            end else if (take_text) begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.too_short = (fill_next < eff_len);
    assign status.byte_eq   = (rdata_reg == scan_reg[0]);
    assign status.last      = (pidx_reg == '0);
    assign status.out_full  = m_valid_reg;

    assign m_valid              = m_valid_reg;
    assign m_match_start        = m_start_reg;
    assign m_position_saturated = m_sat_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(MAX_PATTERN))
        else $error("window fill above store depth");

    a_step_not_past_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (pidx_reg != '0))
        else $error("compare stepped past first pattern byte");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=>
            (m_valid_reg && $stable(m_start_reg) && $stable(m_sat_reg)))
        else $error("result item changed before it was taken");
`endif

endmodule

[rtl/core/npm_ctrl.sv]
// ----------------------------------------------------------------------------
// npm_ctrl
// Controller: input handshake and byte-by-byte compare sequencing.
// ----------------------------------------------------------------------------
module npm_ctrl
    import npm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  logic              m_ready,
    input  npm_status_t       status,
    output npm_cmd_t          cmd
);

    npm_state_t state_reg;
    npm_state_t state_next;
    logic       out_free;

    assign out_free = !status.out_full || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_mode == MODE_TEXT) && !status.too_short) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (!status.byte_eq) begin
                    state_next = ST_IDLE;
                end else if (status.last) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.take     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_COMPARE: begin
                if (status.byte_eq) begin
                    if (status.last) begin
                        cmd.load_out = out_free;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                cmd.load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!status.out_full || m_ready))
        else $error("result loaded over an item not yet taken");

    a_hold_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> status.out_full)
        else $error("waiting on output with no item held");

    a_compare_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_COMPARE) && !status.byte_eq) |=> (state_reg == ST_IDLE))
        else $error("mismatch did not end the compare");
`endif

endmodule
